FILE: rtl/cbs_pkg.sv
// Shared types and constants for the cubic B-spline curve evaluator.
`default_nettype none
package cbs_pkg;

  localparam int MAX_STEPS  = 63;
  localparam int STEPS_W    = 6;
  localparam int COUNT_W    = 16;
  localparam int COORD_W    = 32;
  localparam int T_W        = 25;
  localparam int LANE_DEPTH = 13;

  localparam logic [STEPS_W-1:0] STEPS_RESET = STEPS_W'(8);
  localparam logic [COUNT_W-1:0] MIN_POINTS  = COUNT_W'(5);

  localparam logic CFG_STEPS       = 1'b0;
  localparam logic CFG_POINT_COUNT = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [T_W-1:0] tval_t;

  typedef enum logic [1:0] {
    TG_IDLE,
    TG_RECIP,
    TG_ISSUE
  } tg_state_t;

  // One vertex request from the parameter generator to the lanes.
  typedef struct packed {
    logic  vld;
    tval_t t;
    logic  span_last;
    logic  curve_last;
  } tg_issue_t;

endpackage : cbs_pkg
`default_nettype wire

FILE: rtl/cbs_tgen.sv
// Parameter generator: produces t = round(j/steps) in unsigned 1.24 for j = 0..steps.
`default_nettype none
module cbs_tgen
  import cbs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [STEPS_W-1:0] steps,
  input  wire logic               final_span,
  input  wire logic               en,
  output tg_issue_t               issue,
  output logic                    active
);

  tg_state_t           state_r, state_nxt;
  logic [STEPS_W-1:0]  n_r;
  logic [T_W-1:0]      dvd_r;
  logic [STEPS_W-1:0]  rem_r;
  logic [T_W-1:0]      q0_r;
  logic [2:0]          cnt_r;
  tval_t               t_r;
  logic [STEPS_W-1:0]  frac_r;
  logic [STEPS_W-1:0]  j_r;
  logic                final_r;
  logic [4:0]          qc;
  logic [STEPS_W-1:0]  rc;
  logic [STEPS_W:0]    frac_sum;

  // Five restoring division steps of the dividend by n.
  function automatic logic [10:0] recip_chunk(input logic [STEPS_W-1:0] rem,
                                              input logic [4:0] bits,
                                              input logic [STEPS_W-1:0] n);
    logic [STEPS_W:0] r;
    logic [4:0]       q;
    r = {1'b0, rem};
    q = '0;
    for (int i = 4; i >= 0; i--) begin
      r = {r[STEPS_W-1:0], bits[i]};
      if (r >= {1'b0, n}) begin
        r    = r - {1'b0, n};
        q[i] = 1'b1;
      end
    end
    return {q, r[STEPS_W-1:0]};
  endfunction

  assign {qc, rc}  = recip_chunk(rem_r, dvd_r[T_W-1 -: 5], n_r);
  assign frac_sum  = {1'b0, frac_r} + {1'b0, rem_r};

  // Next state and issue outputs.
  always_comb begin
    state_nxt        = state_r;
    issue.vld        = 1'b0;
    issue.t          = t_r;
    issue.span_last  = (j_r == n_r);
    issue.curve_last = (j_r == n_r) && final_r;
    unique case (state_r)
      TG_IDLE: begin
        if (start) state_nxt = TG_RECIP;
      end
      TG_RECIP: begin
        if (cnt_r == 3'd4) state_nxt = TG_ISSUE;
      end
      TG_ISSUE: begin
        issue.vld = 1'b1;
        if (en && (j_r == n_r)) state_nxt = TG_IDLE;
      end
      default: state_nxt = TG_IDLE;
    endcase
  end

  assign active = (state_r != TG_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TG_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Reciprocal of n by long division, then remainder-stepped t.
  always_ff @(posedge clk) begin
    if (state_r == TG_IDLE && start) begin
      n_r     <= (steps == '0) ? STEPS_W'(1) : steps;
      final_r <= final_span;
      dvd_r   <= T_W'(1) << (T_W - 1);
      rem_r   <= '0;
      q0_r    <= '0;
      cnt_r   <= '0;
    end else if (state_r == TG_RECIP) begin
      q0_r  <= {q0_r[T_W-6:0], qc};
      dvd_r <= dvd_r << 5;
      rem_r <= rc;
      cnt_r <= cnt_r + 3'd1;
      if (cnt_r == 3'd4) begin
        t_r    <= '0;
        frac_r <= n_r >> 1;
        j_r    <= '0;
      end
    end else if (state_r == TG_ISSUE && en) begin
      j_r <= j_r + STEPS_W'(1);
      if (frac_sum >= {1'b0, n_r}) begin
        frac_r <= STEPS_W'(frac_sum - {1'b0, n_r});
        t_r    <= t_r + q0_r + T_W'(1);
      end else begin
        frac_r <= frac_sum[STEPS_W-1:0];
        t_r    <= t_r + q0_r;
      end
    end
  end

endmodule : cbs_tgen
`default_nettype wire

FILE: rtl/cbs_lane.sv
// One axis lane: basis coefficients, Horner evaluation, divide by six, saturate.
`default_nettype none
module cbs_lane
  import cbs_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   en,
  input  wire logic   load,
  input  wire coord_t p0,
  input  wire coord_t p1,
  input  wire coord_t p2,
  input  wire coord_t p3,
  input  wire tval_t  t_in,
  output coord_t      vertex
);

  typedef logic signed [37:0] acc_t;
  typedef logic signed [63:0] prod_t;

  localparam logic [39:0] DIV_BIAS = 40'd824633720835;

  acc_t        a_r, b_r, c_r, d_r;
  prod_t       m1_r, m3_r, m5_r;
  acc_t        s2_r, s4_r;
  acc_t        s6_r;
  tval_t       t1_r, t2_r, t3_r, t4_r;
  logic [39:0] w_r [6];
  logic [39:0] q_r [6];
  logic [1:0]  r_r [6];
  coord_t      vertex_r;
  acc_t        e0, e1, e2, e3;
  logic [39:0] u7;
  logic signed [40:0] v_full;
  logic [9:0]  dc [5];

  // Round a 0.24-scaled product to nearest, halves up.
  function automatic acc_t rnd24(input prod_t p);
    prod_t s;
    s = p + prod_t'(64'sd8388608);
    return acc_t'(s >>> 24);
  endfunction

  // Eight bits of long division by three.
  function automatic logic [9:0] div3_chunk(input logic [1:0] rem, input logic [7:0] bits);
    logic [2:0] r;
    logic [7:0] q;
    r = {1'b0, rem};
    q = '0;
    for (int i = 7; i >= 0; i--) begin
      r = {r[1:0], bits[i]};
      if (r >= 3'd3) begin
        r    = r - 3'd3;
        q[i] = 1'b1;
      end
    end
    return {q, r[1:0]};
  endfunction

  assign e0 = acc_t'(p0);
  assign e1 = acc_t'(p1);
  assign e2 = acc_t'(p2);
  assign e3 = acc_t'(p3);

  // Basis coefficients, taken once per span.
  always_ff @(posedge clk) begin
    if (load) begin
      a_r <= -e0 + 3 * e1 - 3 * e2 + e3;
      b_r <= 3 * e0 - 6 * e1 + 3 * e2;
      c_r <= -3 * e0 + 3 * e2;
      d_r <= e0 + 4 * e1 + e2;
    end
  end

  assign u7     = 40'(s6_r) + DIV_BIAS;
  assign v_full = $signed({1'b0, q_r[5]}) - 41'sd137438953472;

  // Quotient and remainder digits of each division stage.
  always_comb begin
    for (int k = 0; k < 5; k++) dc[k] = div3_chunk(r_r[k], w_r[k][39:32]);
  end

  // Horner pipeline, then floor((acc + 3) / 6) via halving and division by three.
  always_ff @(posedge clk) begin
    if (en) begin
      m1_r <= prod_t'(a_r) * prod_t'({1'b0, t_in});
      t1_r <= t_in;
      s2_r <= rnd24(m1_r) + b_r;
      t2_r <= t1_r;
      m3_r <= prod_t'(s2_r) * prod_t'({1'b0, t2_r});
      t3_r <= t2_r;
      s4_r <= rnd24(m3_r) + c_r;
      t4_r <= t3_r;
      m5_r <= prod_t'(s4_r) * prod_t'({1'b0, t4_r});
      s6_r <= rnd24(m5_r) + d_r;
      w_r[0] <= u7 >> 1;
      q_r[0] <= '0;
      r_r[0] <= '0;
      for (int k = 0; k < 5; k++) begin
        w_r[k+1] <= w_r[k] << 8;
        q_r[k+1] <= {q_r[k][31:0], dc[k][9:2]};
        r_r[k+1] <= dc[k][1:0];
      end
      if (v_full > 41'sd2147483647) begin
        vertex_r <= coord_t'(32'h7FFF_FFFF);
      end else if (v_full < -41'sd2147483648) begin
        vertex_r <= coord_t'(32'h8000_0000);
      end else begin
        vertex_r <= coord_t'(v_full);
      end
    end
  end

  assign vertex = vertex_r;

endmodule : cbs_lane
`default_nettype wire

FILE: rtl/cubic_bspline_curve_3d_top.sv
// Top level of the uniform cubic B-spline curve evaluator, three axis lanes.
//
// Control points enter on the in_ channel, one per transfer, as signed 16.16
// (x, y, z) plus first_point, which starts a new curve. From the fourth point
// of a curve of at least five points (point_count), each point produces one
// span of steps+1 vertices (two if steps is 0) on the out_ channel;
// span_last marks the last vertex of a span and curve_last the last
// vertex of the curve. Steps and point_count are set over the APB port
// (byte addresses 0 and 4). A point that makes no span does not raise
// in_stall. A point that makes a span holds in_stall high until the cycle
// after its last vertex has been transferred: first the reciprocal
// division of 2^24 by steps, then one vertex per cycle while out_stall is
// low, through a 13-stage lane pipeline and the output register.
// When out_stall is high while out_valid is high, the whole vertex pipeline holds its contents.
// Reset clears the point window, the point count and the output valid, and
// sets steps to 8 and point_count to 0.
`default_nettype none
module cubic_bspline_curve_3d_top
  import cbs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire coord_t      in_point_x,
  input  wire coord_t      in_point_y,
  input  wire coord_t      in_point_z,
  input  wire logic        in_first_point,
  output logic             out_valid,
  input  wire logic        out_stall,
  output coord_t           out_vertex_x,
  output coord_t           out_vertex_y,
  output coord_t           out_vertex_z,
  output logic             out_span_last,
  output logic             out_curve_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [STEPS_W-1:0] steps_r;
  logic [COUNT_W-1:0] point_count_r;
  coord_t             win_r [3][3];
  logic [COUNT_W-1:0] seen_r;
  logic               busy_r;
  logic [LANE_DEPTH-1:0] pv_r, ps_r, pc_r;
  logic               out_valid_r, out_span_r, out_curve_r;
  coord_t             out_x_r, out_y_r, out_z_r;
  logic               accept, emit, en, tg_active;
  logic [COUNT_W-1:0] old_seen;
  coord_t             pin [3];
  coord_t             lane_v [3];
  coord_t             w0 [3], w1 [3], w2 [3];
  tg_issue_t          issue;

  // Configuration registers.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r       <= STEPS_RESET;
      point_count_r <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        CFG_STEPS:       steps_r       <= pwdata[STEPS_W-1:0];
        CFG_POINT_COUNT: point_count_r <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      CFG_STEPS:       prdata = 32'(steps_r);
      CFG_POINT_COUNT: prdata = 32'(point_count_r);
      default:         prdata = '0;
    endcase
  end

  // Point window and curve bookkeeping.
  assign in_stall = busy_r;
  assign accept   = in_valid && !busy_r;
  assign old_seen = in_first_point ? '0 : seen_r;
  assign emit     = (point_count_r >= MIN_POINTS) && (old_seen >= COUNT_W'(3)) &&
                    (old_seen < point_count_r);
  assign pin[0]   = in_point_x;
  assign pin[1]   = in_point_y;
  assign pin[2]   = in_point_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) win_r[i][k] <= '0;
      end
    end else if (accept) begin
      seen_r <= (old_seen == '1) ? old_seen : old_seen + COUNT_W'(1);
      for (int k = 0; k < 3; k++) begin
        win_r[0][k] <= in_first_point ? '0 : win_r[1][k];
        win_r[1][k] <= in_first_point ? '0 : win_r[2][k];
        win_r[2][k] <= pin[k];
      end
    end
  end

  // Busy from a span-making transfer until its last vertex is transferred.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (accept && emit) begin
      busy_r <= 1'b1;
    end else if (busy_r && !tg_active && !(|pv_r) && !out_valid_r) begin
      busy_r <= 1'b0;
    end
  end

  assign en = !out_valid_r || !out_stall;

  cbs_tgen u_tgen (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (accept && emit),
    .steps      (steps_r),
    .final_span (old_seen + COUNT_W'(1) == point_count_r),
    .en         (en),
    .issue      (issue),
    .active     (tg_active)
  );

  // Three axis lanes working side by side.
  for (genvar g = 0; g < 3; g++) begin : g_lane
    assign w0[g] = win_r[0][g];
    assign w1[g] = win_r[1][g];
    assign w2[g] = win_r[2][g];
    cbs_lane u_lane (
      .clk    (clk),
      .en     (en),
      .load   (accept && emit),
      .p0     (w0[g]),
      .p1     (w1[g]),
      .p2     (w2[g]),
      .p3     (pin[g]),
      .t_in   (issue.t),
      .vertex (lane_v[g])
    );
  end

  // Valid and flag line alongside the lane pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else if (en) begin
      pv_r <= {pv_r[LANE_DEPTH-2:0], issue.vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ps_r <= {ps_r[LANE_DEPTH-2:0], issue.span_last};
      pc_r <= {pc_r[LANE_DEPTH-2:0], issue.curve_last};
    end
  end

  // Merge stage: the output register gathers the three lanes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= pv_r[LANE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x_r     <= lane_v[0];
      out_y_r     <= lane_v[1];
      out_z_r     <= lane_v[2];
      out_span_r  <= ps_r[LANE_DEPTH-1];
      out_curve_r <= pc_r[LANE_DEPTH-1];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_vertex_x   = out_x_r;
  assign out_vertex_y   = out_y_r;
  assign out_vertex_z   = out_z_r;
  assign out_span_last  = out_span_r;
  assign out_curve_last = out_curve_r;

`ifndef SYNTHESIS
  a_out_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> busy_r) else $error("vertex outside a span");
  a_tgen_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tg_active |-> busy_r) else $error("generator running while idle");
  a_curve_on_span: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_curve_r) |-> out_span_r) else $error("curve end off span end");
  a_pipe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (pv_r == '0)) else $error("pipeline busy while idle");
`endif

endmodule : cubic_bspline_curve_3d_top
`default_nettype wire
